// ===== hdl/gpt_pkg.sv =====
package gpt_pkg;

  localparam int unsigned TIME_WIDTH_DEF  = 16;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FORCE_ACT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FORCE_IDLE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TOGGLE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TRAIN      = 3'd4;

  localparam logic [PADDR_W-1:0] ADDR_IDLE_LEVEL = 2'd0;

  typedef struct packed {
    logic pin_level;
    logic status;
    logic in_active_phase;
  } result_t;

endpackage

// ===== hdl/gpt_core.sv =====
module gpt_core #(
  parameter int unsigned TIME_WIDTH  = gpt_pkg::TIME_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = gpt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_level_i,
  input  logic                            accept_i,
  input  logic [gpt_pkg::CMD_W-1:0]       command_i,
  input  logic signed [gpt_pkg::FIELD_W-1:0] pulse_count_i,
  input  logic [gpt_pkg::FIELD_W-1:0]     on_ticks_i,
  input  logic [gpt_pkg::FIELD_W-1:0]     off_ticks_i,
  output logic                            idle_level_o,
  output gpt_pkg::result_t                result_o
);

  localparam logic [32:0] TimeMax = (33'd1 << TIME_WIDTH) - 33'd1;
  localparam logic signed [32:0] CountHi = (33'sd1 <<< (COUNT_WIDTH - 1)) - 33'sd1;
  localparam logic signed [32:0] CountLo = -CountHi - 33'sd1;

  logic                          idle_q, idle_d;
  logic                          pin_q, pin_d;
  logic                          phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]        left_q, left_d;
  logic [TIME_WIDTH-1:0]         elapsed_q, elapsed_d;
  logic [TIME_WIDTH-1:0]         hold_q, hold_d;
  logic [TIME_WIDTH-1:0]         gap_q, gap_d;
  logic                          status;

  logic [TIME_WIDTH-1:0]         el_inc;
  logic                          left_pos;
  logic [COUNT_WIDTH-1:0]        left_dec;
  logic [32:0]                   on_ext, off_ext, on_sat, off_sat;
  logic signed [32:0]            cnt_ext, cnt_sat;
  logic [COUNT_WIDTH-1:0]        cnt_trim, cnt_load;

  // Saturating tick counter and pulse countdown helpers.
  assign el_inc   = (elapsed_q == '1) ? elapsed_q : elapsed_q + TIME_WIDTH'(1);
  assign left_pos = !left_q[COUNT_WIDTH-1] && (left_q != '0);
  assign left_dec = left_pos ? left_q - COUNT_WIDTH'(1) : left_q;

  // Load values for a new train, clamped to the configured widths.
  assign on_ext   = {17'd0, on_ticks_i};
  assign off_ext  = {17'd0, off_ticks_i};
  assign on_sat   = (on_ext > TimeMax) ? TimeMax : on_ext;
  assign off_sat  = (off_ext > TimeMax) ? TimeMax : off_ext;
  assign cnt_ext  = {{17{pulse_count_i[gpt_pkg::FIELD_W-1]}}, pulse_count_i};
  assign cnt_sat  = (cnt_ext > CountHi) ? CountHi : ((cnt_ext < CountLo) ? CountLo : cnt_ext);
  assign cnt_trim = cnt_sat[COUNT_WIDTH-1:0];
  assign cnt_load = (cnt_sat > 33'sd0) ? cnt_trim - COUNT_WIDTH'(1) : cnt_trim;

  always_comb begin
    idle_d    = idle_q;
    pin_d     = pin_q;
    phase_d   = phase_q;
    left_d    = left_q;
    elapsed_d = elapsed_q;
    hold_d    = hold_q;
    gap_d     = gap_q;
    status    = 1'b0;
    if (cfg_we_i) begin
      idle_d = cfg_level_i;
      pin_d  = cfg_level_i;
    end else if (accept_i) begin
      case (command_i)
        gpt_pkg::CMD_TICK: begin
          elapsed_d = el_inc;
          if (phase_q) begin
            if (el_inc >= hold_q) begin
              phase_d = 1'b0;
              // A zero gap leaves the pin active until the next pulse.
              if (gap_q != '0) begin
                pin_d     = idle_q;
                elapsed_d = '0;
              end
            end
          end else if ((left_q != '0) && (el_inc >= gap_q)) begin
            phase_d   = 1'b1;
            left_d    = left_dec;
            pin_d     = ~idle_q;
            elapsed_d = '0;
          end
        end
        gpt_pkg::CMD_FORCE_ACT: begin
          phase_d = 1'b0;
          left_d  = '0;
          pin_d   = ~idle_q;
        end
        gpt_pkg::CMD_FORCE_IDLE: begin
          phase_d = 1'b0;
          left_d  = '0;
          pin_d   = idle_q;
        end
        gpt_pkg::CMD_TOGGLE: begin
          phase_d = 1'b0;
          left_d  = '0;
          pin_d   = ~pin_q;
        end
        gpt_pkg::CMD_TRAIN: begin
          if (pulse_count_i == '0) begin
            status = 1'b1;
          end else begin
            phase_d   = 1'b1;
            left_d    = cnt_load;
            hold_d    = on_sat[TIME_WIDTH-1:0];
            gap_d     = off_sat[TIME_WIDTH-1:0];
            elapsed_d = '0;
            pin_d     = ~idle_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q    <= 1'b0;
      pin_q     <= 1'b0;
      phase_q   <= 1'b0;
      left_q    <= '0;
      elapsed_q <= '0;
      hold_q    <= '0;
      gap_q     <= '0;
    end else begin
      idle_q    <= idle_d;
      pin_q     <= pin_d;
      phase_q   <= phase_d;
      left_q    <= left_d;
      elapsed_q <= elapsed_d;
      hold_q    <= hold_d;
      gap_q     <= gap_d;
    end
  end

  assign idle_level_o              = idle_q;
  assign result_o.pin_level        = pin_d;
  assign result_o.status           = status;
  assign result_o.in_active_phase  = phase_d;

endmodule

// ===== hdl/gpt_skid.sv =====
module gpt_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  gpt_pkg::result_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output gpt_pkg::result_t out_data_o
);

  logic             out_valid_q, skid_valid_q;
  gpt_pkg::result_t out_q, skid_q;
  logic             accept, take;

  assign accept = in_valid_i && !skid_valid_q;
  assign take   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  // The skid slot catches a beat that arrives while the output is held.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || take) begin
        out_q <= in_data_i;
      end else begin
        skid_q <= in_data_i;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/gpio_pulse_train_output.sv =====
// An accepted command's result beat is registered in the output buffer, or held
// in the skid slot while the output is stalled. Throughput: one command per cycle
// while in_stall_o is low; the state update is a single registered step of compares
// and counter updates, with a two-entry output buffer. Reset (rst_ni low,
// asynchronous): idle level 0, pin 0, idle phase, all counters zero, output buffer empty.
module gpio_pulse_train_output #(
  parameter int unsigned TIME_WIDTH  = gpt_pkg::TIME_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = gpt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gpt_pkg::PADDR_W-1:0]        paddr,
  input  logic [gpt_pkg::PDATA_W-1:0]        pwdata,
  output logic [gpt_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [gpt_pkg::CMD_W-1:0]          command_i,
  input  logic signed [gpt_pkg::FIELD_W-1:0] pulse_count_i,
  input  logic [gpt_pkg::FIELD_W-1:0]        on_ticks_i,
  input  logic [gpt_pkg::FIELD_W-1:0]        off_ticks_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               pin_level_o,
  output logic                               status_o,
  output logic                               in_active_phase_o
);

  logic             cfg_we;
  logic             accept;
  logic             idle_level;
  gpt_pkg::result_t result, out_data;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == gpt_pkg::ADDR_IDLE_LEVEL);
  assign prdata = (paddr == gpt_pkg::ADDR_IDLE_LEVEL) ?
                  {{(gpt_pkg::PDATA_W-1){1'b0}}, idle_level} : '0;
  assign accept = in_valid_i && !in_stall_o;

  gpt_core #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_level_i   (pwdata[0]),
    .accept_i      (accept),
    .command_i     (command_i),
    .pulse_count_i (pulse_count_i),
    .on_ticks_i    (on_ticks_i),
    .off_ticks_i   (off_ticks_i),
    .idle_level_o  (idle_level),
    .result_o      (result)
  );

  gpt_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign pin_level_o       = out_data.pin_level;
  assign status_o          = out_data.status;
  assign in_active_phase_o = out_data.in_active_phase;

endmodule

// ===== hdl/gpt_checker.sv =====
module gpt_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [gpt_pkg::PADDR_W-1:0]        paddr,
  input logic [gpt_pkg::PDATA_W-1:0]        pwdata,
  input logic [gpt_pkg::PDATA_W-1:0]        prdata,
  input logic                               pready,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [gpt_pkg::CMD_W-1:0]          command_i,
  input logic signed [gpt_pkg::FIELD_W-1:0] pulse_count_i,
  input logic [gpt_pkg::FIELD_W-1:0]        on_ticks_i,
  input logic [gpt_pkg::FIELD_W-1:0]        off_ticks_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               pin_level_o,
  input logic                               status_o,
  input logic                               in_active_phase_o
);

  logic in_beat, empty_in;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign empty_in = in_beat && !out_valid_o;

  // Input back-pressure only appears once the output holds a beat.
  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pin_level_o) &&
      $stable(status_o) && $stable(in_active_phase_o))
    else $error("stalled output beat changed");

  // A zero-count train is rejected with status set; the running phase stays as it was.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_in && (command_i == gpt_pkg::CMD_TRAIN) && (pulse_count_i == '0)
      |=> out_valid_o && status_o)
    else $error("zero-count train not rejected");

  a_train_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_in && (command_i == gpt_pkg::CMD_TRAIN) && (pulse_count_i != '0)
      |=> out_valid_o && !status_o && in_active_phase_o)
    else $error("train did not enter active phase");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr == gpt_pkg::ADDR_IDLE_LEVEL)
      |=> (paddr != gpt_pkg::ADDR_IDLE_LEVEL) || (prdata[0] == $past(pwdata[0])))
    else $error("idle level readback mismatch");

endmodule

bind gpio_pulse_train_output gpt_checker u_gpt_checker (.*);

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned MAX_REPORTS = 10;
  // An address with no register behind it; writes to it must be ignored.
  localparam logic [gpt_pkg::PADDR_W-1:0] ADDR_SPARE = gpt_pkg::ADDR_IDLE_LEVEL + 1'b1;
  localparam logic signed [gpt_pkg::FIELD_W-1:0] COUNT_MAX =
    {1'b0, {(gpt_pkg::FIELD_W-1){1'b1}}};
  localparam logic signed [gpt_pkg::FIELD_W-1:0] COUNT_MIN =
    {1'b1, {(gpt_pkg::FIELD_W-1){1'b0}}};

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [gpt_pkg::PADDR_W-1:0]        paddr = '0;
  logic [gpt_pkg::PDATA_W-1:0]        pwdata = '0;
  logic [gpt_pkg::PDATA_W-1:0]        prdata;
  logic                               pready;
  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic [gpt_pkg::CMD_W-1:0]          command_i = '0;
  logic signed [gpt_pkg::FIELD_W-1:0] pulse_count_i = '0;
  logic [gpt_pkg::FIELD_W-1:0]        on_ticks_i = '0;
  logic [gpt_pkg::FIELD_W-1:0]        off_ticks_i = '0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic                               pin_level_o;
  logic                               status_o;
  logic                               in_active_phase_o;

  bit          idle_bursts = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned sent_beats = 0;

  class pin_train_scoreboard;
    logic                               idle_lvl;
    logic                               pin;
    logic                               active;
    logic signed [gpt_pkg::FIELD_W-1:0] left;
    logic [gpt_pkg::FIELD_W-1:0]        elapsed;
    logic [gpt_pkg::FIELD_W-1:0]        hold;
    logic [gpt_pkg::FIELD_W-1:0]        gap;
    gpt_pkg::result_t                   expected_pin_states[$];
    int unsigned                        n_fail;
    int unsigned                        n_checked;

    function new();
      idle_lvl  = 1'b0;
      pin       = 1'b0;
      active    = 1'b0;
      left      = '0;
      elapsed   = '0;
      hold      = '0;
      gap       = '0;
      n_fail    = 0;
      n_checked = 0;
    endfunction

    function void set_idle_level(logic lvl);
      idle_lvl = lvl;
      pin      = lvl;
    endfunction

    function void start_pulse();
      active = 1'b1;
      if (left > 0) left--;
      pin     = ~idle_lvl;
      elapsed = '0;
    endfunction

    // The elapsed count saturates before either phase looks at it.
    function void apply_tick();
      if (elapsed != '1) elapsed++;
      if (active) begin
        if (elapsed >= hold) begin
          active = 1'b0;
          // With no gap the pin stays active and the count keeps running.
          if (gap != '0) begin
            pin     = idle_lvl;
            elapsed = '0;
          end
        end
      end else if (left != 0 && elapsed >= gap) begin
        start_pulse();
      end
    endfunction

    function void note_command(logic [gpt_pkg::CMD_W-1:0] cmd,
                               logic signed [gpt_pkg::FIELD_W-1:0] cnt,
                               logic [gpt_pkg::FIELD_W-1:0] on,
                               logic [gpt_pkg::FIELD_W-1:0] off);
      gpt_pkg::result_t want;
      logic             rejected;
      rejected = 1'b0;
      case (cmd)
        gpt_pkg::CMD_TICK: apply_tick();
        gpt_pkg::CMD_FORCE_ACT: begin
          active = 1'b0;
          left   = '0;
          pin    = ~idle_lvl;
        end
        gpt_pkg::CMD_FORCE_IDLE: begin
          active = 1'b0;
          left   = '0;
          pin    = idle_lvl;
        end
        gpt_pkg::CMD_TOGGLE: begin
          active = 1'b0;
          left   = '0;
          pin    = ~pin;
        end
        gpt_pkg::CMD_TRAIN: begin
          if (cnt == 0) begin
            rejected = 1'b1;
          end else begin
            left = cnt;
            hold = on;
            gap  = off;
            start_pulse();
          end
        end
        default: ;
      endcase
      want.pin_level       = pin;
      want.status          = rejected;
      want.in_active_phase = active;
      expected_pin_states.push_back(want);
    endfunction

    function void report(string msg);
      n_fail++;
      if (n_fail <= MAX_REPORTS) $display("ERROR: result %0d: %s", n_checked, msg);
    endfunction

    function void compare_bit(string field, logic want, logic got);
      if (got !== want) report($sformatf("%s expected %0b, got %0b", field, want, got));
    endfunction

    function void check_pin_result(gpt_pkg::result_t got);
      gpt_pkg::result_t want;
      if (expected_pin_states.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = expected_pin_states.pop_front();
        compare_bit("pin_level", want.pin_level, got.pin_level);
        compare_bit("status", want.status, got.status);
        compare_bit("in_active_phase", want.in_active_phase, got.in_active_phase);
      end
      n_checked++;
    endfunction
  endclass

  pin_train_scoreboard sb = new();

  gpio_pulse_train_output u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .pulse_count_i     (pulse_count_i),
    .on_ticks_i        (on_ticks_i),
    .off_ticks_i       (off_ticks_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pin_level_o       (pin_level_o),
    .status_o          (status_o),
    .in_active_phase_o (in_active_phase_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: check every beat and stall in short bursts or one long hold.
  initial begin
    int unsigned      stall_left;
    gpt_pkg::result_t got;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.pin_level       = pin_level_o;
        got.status          = status_o;
        got.in_active_phase = in_active_phase_o;
        sb.check_pin_result(got);
      end
      if (stall_left == 0) begin
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          stall_left    = LONG_HOLD;
        end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 4);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= WDOG_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  task automatic send_beat(input logic [gpt_pkg::CMD_W-1:0] cmd,
                           input logic signed [gpt_pkg::FIELD_W-1:0] cnt,
                           input logic [gpt_pkg::FIELD_W-1:0] on,
                           input logic [gpt_pkg::FIELD_W-1:0] off);
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    pulse_count_i <= cnt;
    on_ticks_i    <= on;
    off_ticks_i   <= off;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(cmd, cnt, on, off);
    sent_beats++;
  endtask

  // Ticks carry random payload; the block must ignore it.
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_beat(gpt_pkg::CMD_TICK, gpt_pkg::FIELD_W'($urandom),
                         gpt_pkg::FIELD_W'($urandom), gpt_pkg::FIELD_W'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_pin_states.size() != 0);
  endtask

  task automatic write_reg(input logic [gpt_pkg::PADDR_W-1:0] addr,
                           input logic [gpt_pkg::PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == gpt_pkg::ADDR_IDLE_LEVEL) sb.set_idle_level(data[0]);
  endtask

  function automatic logic signed [gpt_pkg::FIELD_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return gpt_pkg::FIELD_W'($urandom);
      2: return -gpt_pkg::FIELD_W'($urandom_range(1, 3));
      3: return ($urandom_range(0, 1) != 0) ? COUNT_MAX : COUNT_MIN;
      default: return gpt_pkg::FIELD_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [gpt_pkg::FIELD_W-1:0] pick_ticks();
    case ($urandom_range(0, 9))
      0: return gpt_pkg::FIELD_W'($urandom);
      1: return '1;
      default: return gpt_pkg::FIELD_W'($urandom_range(0, 4));
    endcase
  endfunction

  // Mostly a train followed by one to 24 ticks, with the
  // occasional stray command in between.
  task automatic random_episode();
    logic signed [gpt_pkg::FIELD_W-1:0] cnt;
    logic [gpt_pkg::FIELD_W-1:0]        on;
    logic [gpt_pkg::FIELD_W-1:0]        off;
    if ($urandom_range(0, 9) < 7) begin
      cnt = pick_count();
      on  = pick_ticks();
      off = pick_ticks();
      send_beat(gpt_pkg::CMD_TRAIN, cnt, on, off);
      send_ticks($urandom_range(1, 24));
    end else begin
      send_beat(gpt_pkg::CMD_W'($urandom_range(0, (1 << gpt_pkg::CMD_W) - 1)),
                gpt_pkg::FIELD_W'($urandom), gpt_pkg::FIELD_W'($urandom),
                gpt_pkg::FIELD_W'($urandom));
    end
  endtask

  task automatic random_phase(input int unsigned n_beats);
    int unsigned first;
    first = sent_beats;
    while (sent_beats - first < n_beats) random_episode();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(ADDR_SPARE, gpt_pkg::PDATA_W'(1));

    send_ticks(1);
    send_beat(gpt_pkg::CMD_TICK, '1, '1, '1);
    send_beat(gpt_pkg::CMD_FORCE_ACT, '0, '0, '0);
    send_beat(gpt_pkg::CMD_TOGGLE, '0, '0, '0);
    send_beat(gpt_pkg::CMD_FORCE_IDLE, '0, '0, '0);
    send_beat(gpt_pkg::CMD_TOGGLE, '1, '1, '1);
    for (int c = gpt_pkg::CMD_TRAIN + 1; c < (1 << gpt_pkg::CMD_W); c++) begin
      send_beat(gpt_pkg::CMD_W'(c), gpt_pkg::FIELD_W'($urandom),
                gpt_pkg::FIELD_W'($urandom), gpt_pkg::FIELD_W'($urandom));
    end
    send_beat(gpt_pkg::CMD_TRAIN, '0, '1, '1);
    send_beat(gpt_pkg::CMD_TRAIN, 16'sd3, 16'd2, 16'd1);
    send_ticks(10);
    send_beat(gpt_pkg::CMD_TRAIN, -16'sd1, '0, '0);
    send_ticks(4);
    send_beat(gpt_pkg::CMD_TRAIN, COUNT_MAX, 16'd1, '1);
    send_ticks(3);
    send_beat(gpt_pkg::CMD_FORCE_IDLE, '0, '0, '0);
    send_beat(gpt_pkg::CMD_TRAIN, COUNT_MIN, 16'd3, '0);
    send_ticks(5);
    send_beat(gpt_pkg::CMD_TOGGLE, '0, '0, '0);

    // Single pulse with no gap: the pin stays active once the pulse ends.
    send_beat(gpt_pkg::CMD_TRAIN, 16'sd1, 16'd2, '0);
    send_ticks(6);
    wait_drained();

    write_reg(gpt_pkg::ADDR_IDLE_LEVEL, gpt_pkg::PDATA_W'(1));
    long_hold_req = 1'b1;
    random_phase(130);
    wait_drained();

    write_reg(gpt_pkg::ADDR_IDLE_LEVEL, gpt_pkg::PDATA_W'(0));
    random_phase(60);
    wait_drained();
    random_phase(60);
    wait_drained();

    write_reg(gpt_pkg::ADDR_IDLE_LEVEL, gpt_pkg::PDATA_W'(1));
    random_phase(120);
    wait_drained();

    write_reg(gpt_pkg::ADDR_IDLE_LEVEL, gpt_pkg::PDATA_W'(0));
    idle_bursts = 1'b0;
    random_phase(120);
    wait_drained();
    repeat (4) @(posedge clk_i);

    sb.n_fail += sb.expected_pin_states.size();
    if (sb.n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
